/* rtl/core/tbd_pkg.sv */
// ----------------------------------------------------------------------------
// tbd_pkg
// Shared types, glyph codes and drawing-part codes for the text box draw
// sequencer.
// ----------------------------------------------------------------------------
package tbd_pkg;

  // default screen geometry
  localparam int DefScreenCols = 80;
  localparam int DefScreenRows = 25;

  // most cell writes issued for one command
  localparam int MaxWrites = 52;
  localparam int CntW      = $clog2(MaxWrites);

  // field widths
  localparam int PageW  = 3;
  localparam int ColW   = 7;
  localparam int RowW   = 5;
  localparam int AttrW  = 8;
  localparam int StyleW = 2;
  localparam int MaskW  = 8;
  localparam int CharW  = 8;
  localparam int RunW   = 7;

  localparam int InDataW  = 48;
  localparam int OutDataW = 40;

  // drawing parts, in issue order
  localparam int NumPh = 11;
  localparam int PhW   = 4;
  typedef logic [PhW-1:0] phase_t;

  localparam phase_t PH_SINGLE = 4'd0;
  localparam phase_t PH_VLINE  = 4'd1;
  localparam phase_t PH_HLINE  = 4'd2;
  localparam phase_t PH_TOP    = 4'd3;
  localparam phase_t PH_UR     = 4'd4;
  localparam phase_t PH_RIGHT  = 4'd5;
  localparam phase_t PH_LR     = 4'd6;
  localparam phase_t PH_BOTTOM = 4'd7;
  localparam phase_t PH_LL     = 4'd8;
  localparam phase_t PH_LEFT   = 4'd9;
  localparam phase_t PH_UL     = 4'd10;

  // configuration register indexes
  localparam logic REG_GLYPH_SET   = 1'b0;
  localparam logic REG_LOWER_RIGHT = 1'b1;

  // box styles
  localparam logic [StyleW-1:0] STYLE_SINGLE = 2'd1;
  localparam logic [StyleW-1:0] STYLE_DOUBLE = 2'd2;

  // ASCII glyphs
  localparam logic [CharW-1:0] CH_DASH = 8'h2D;
  localparam logic [CharW-1:0] CH_BAR  = 8'h7C;
  localparam logic [CharW-1:0] CH_PLUS = 8'h2B;
  localparam logic [CharW-1:0] CH_STAR = 8'h2A;

  // CP437 single-line glyphs
  localparam logic [CharW-1:0] CH_S_HZ = 8'hC4;
  localparam logic [CharW-1:0] CH_S_VT = 8'hB3;
  localparam logic [CharW-1:0] CH_S_UL = 8'hDA;
  localparam logic [CharW-1:0] CH_S_UR = 8'hBF;
  localparam logic [CharW-1:0] CH_S_LR = 8'hD9;
  localparam logic [CharW-1:0] CH_S_LL = 8'hC0;

  // CP437 double-line glyphs
  localparam logic [CharW-1:0] CH_D_HZ = 8'hCD;
  localparam logic [CharW-1:0] CH_D_VT = 8'hBA;
  localparam logic [CharW-1:0] CH_D_UL = 8'hC9;
  localparam logic [CharW-1:0] CH_D_UR = 8'hBB;
  localparam logic [CharW-1:0] CH_D_LR = 8'hBC;
  localparam logic [CharW-1:0] CH_D_LL = 8'hC8;

  // CP437 single-cell marks
  localparam logic [CharW-1:0] CH_DOT    = 8'h07;
  localparam logic [CharW-1:0] CH_CIRCLE = 8'h09;

  typedef struct packed {
    logic   load;        // capture the command
    logic   emit;        // write the output register
    logic   last;        // final write of the command
    phase_t phase;       // part being drawn
    logic   row_init_br; // row <= top_row (full vertical line)
    logic   row_init_in; // row <= top_row + 1 (side edge)
    logic   row_inc;
  } tbd_cmd_t;

  typedef struct packed {
    logic [NumPh-1:0] has;   // parts with at least one write
    logic             row_at_br;
    logic             row_at_brm1;
    logic             out_free;
  } tbd_stat_t;

  typedef struct packed {
    logic   found;
    phase_t idx;
  } ph_sel_t;

  // lowest part at or above lo that has writes
  function automatic ph_sel_t first_from(logic [NumPh-1:0] has, phase_t lo);
    ph_sel_t s;
    s.found = 1'b0;
    s.idx   = PH_SINGLE;
    for (int i = NumPh - 1; i >= 0; i--) begin
      if (has[i] && (PhW'(i) >= lo)) begin
        s.found = 1'b1;
        s.idx   = PhW'(i);
      end
    end
    return s;
  endfunction

endpackage

/* rtl/core/tbd_datapath.sv */
// ----------------------------------------------------------------------------
// tbd_datapath
// Command registers, configuration registers, row counter, part decode and
// the output register of the box draw sequencer.
// ----------------------------------------------------------------------------
module tbd_datapath #(
  parameter int SCREEN_COLS = tbd_pkg::DefScreenCols,
  parameter int SCREEN_ROWS = tbd_pkg::DefScreenRows
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tbd_pkg::InDataW-1:0]   in_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic                          cfg_data,
  input  tbd_pkg::tbd_cmd_t             cmd,
  output tbd_pkg::tbd_stat_t            stat,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tbd_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast
);
  import tbd_pkg::*;

  logic              glyph_set;
  logic              lower_right_enable;

  logic [PageW-1:0]  page;
  logic [ColW-1:0]   lc;
  logic [RowW-1:0]   tr;
  logic [ColW-1:0]   rc;
  logic [RowW-1:0]   br;
  logic [AttrW-1:0]  attr;
  logic [StyleW-1:0] style;
  logic [MaskW-1:0]  mask;
  logic [RowW-1:0]   row;

  logic              ovalid;
  logic [PageW-1:0]  o_page;
  logic [ColW-1:0]   o_col;
  logic [RowW-1:0]   o_row;
  logic [CharW-1:0]  o_char;
  logic [AttrW-1:0]  o_attr;
  logic [RunW-1:0]   o_run;
  logic              o_last;

  logic onscreen, upright, single, style_ok, norm, vline, hline, box;
  logic col_inner, row_inner;
  logic [CharW-1:0] hz, vt, ul, ur, lr, ll, single_ch;
  logic [ColW-1:0]  w_col;
  logic [RowW-1:0]  w_row;
  logic [CharW-1:0] w_char;
  logic [RunW-1:0]  w_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_set          <= 1'b0;
      lower_right_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GLYPH_SET:   glyph_set          <= cfg_data;
        REG_LOWER_RIGHT: lower_right_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page  <= in_data[2:0];
      lc    <= in_data[9:3];
      tr    <= in_data[14:10];
      rc    <= in_data[21:15];
      br    <= in_data[26:22];
      attr  <= in_data[34:27];
      style <= in_data[36:35];
      mask  <= in_data[44:37];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_init_br) begin
      row <= tr;
    end else if (cmd.row_init_in) begin
      row <= RowW'(tr + 5'd1);
    end else if (cmd.row_inc) begin
      row <= RowW'(row + 5'd1);
    end
  end

  // part decode
  always_comb begin
    onscreen  = (9'(lc) < 9'(SCREEN_COLS)) && (9'(rc) < 9'(SCREEN_COLS)) &&
                (6'(tr) < 6'(SCREEN_ROWS)) && (6'(br) < 6'(SCREEN_ROWS));
    upright   = (lc <= rc) && (tr <= br);
    single    = (lc == rc) && (tr == br);
    style_ok  = !glyph_set || (style == STYLE_SINGLE) || (style == STYLE_DOUBLE);
    norm      = onscreen && upright && !single && style_ok;
    vline     = norm && (lc == rc) && (mask[6] || mask[2]);
    hline     = norm && !vline && (tr == br) && (mask[4] || mask[0]);
    box       = norm && !vline && !hline;
    col_inner = (8'(lc) + 8'd1) < 8'(rc);
    row_inner = (6'(tr) + 6'd1) < 6'(br);

    stat.has            = '0;
    stat.has[PH_SINGLE] = onscreen && upright && single;
    stat.has[PH_VLINE]  = vline;
    stat.has[PH_HLINE]  = hline;
    stat.has[PH_TOP]    = box && col_inner && mask[0];
    stat.has[PH_UR]     = box && mask[1];
    stat.has[PH_RIGHT]  = box && row_inner && mask[2];
    stat.has[PH_LR]     = box && lower_right_enable && mask[3];
    stat.has[PH_BOTTOM] = box && col_inner && mask[4];
    stat.has[PH_LL]     = box && mask[5];
    stat.has[PH_LEFT]   = box && row_inner && mask[6];
    stat.has[PH_UL]     = box && mask[7];
    stat.row_at_br      = (row == br);
    stat.row_at_brm1    = (row == RowW'(br - 5'd1));
    stat.out_free       = !ovalid || m_axis_tready;
  end

  // glyph selection
  always_comb begin
    if (!glyph_set) begin
      hz = CH_DASH; vt = CH_BAR;
      ul = CH_PLUS; ur = CH_PLUS; lr = CH_PLUS; ll = CH_PLUS;
      single_ch = CH_STAR;
    end else begin
      if (style == STYLE_DOUBLE) begin
        hz = CH_D_HZ; vt = CH_D_VT;
        ul = CH_D_UL; ur = CH_D_UR; lr = CH_D_LR; ll = CH_D_LL;
      end else begin
        hz = CH_S_HZ; vt = CH_S_VT;
        ul = CH_S_UL; ur = CH_S_UR; lr = CH_S_LR; ll = CH_S_LL;
      end
      single_ch = (style != '0) ? CH_DOT : CH_CIRCLE;
    end
  end

  always_comb begin
    w_col  = lc;
    w_row  = tr;
    w_char = single_ch;
    w_run  = RunW'(1);
    unique case (cmd.phase)
      PH_SINGLE: ;
      PH_VLINE: begin
        w_row = row; w_char = vt;
      end
      PH_HLINE: begin
        w_char = hz; w_run = RunW'(rc - lc + 7'd1);
      end
      PH_TOP: begin
        w_col = ColW'(lc + 7'd1); w_char = hz; w_run = RunW'(rc - lc - 7'd1);
      end
      PH_UR: begin
        w_col = rc; w_char = ur;
      end
      PH_RIGHT: begin
        w_col = rc; w_row = row; w_char = vt;
      end
      PH_LR: begin
        w_col = rc; w_row = br; w_char = lr;
      end
      PH_BOTTOM: begin
        w_col = ColW'(lc + 7'd1); w_row = br; w_char = hz;
        w_run = RunW'(rc - lc - 7'd1);
      end
      PH_LL: begin
        w_row = br; w_char = ll;
      end
      PH_LEFT: begin
        w_row = row; w_char = vt;
      end
      PH_UL: begin
        w_char = ul;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (cmd.emit) begin
      ovalid <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_page <= page;
      o_col  <= w_col;
      o_row  <= w_row;
      o_char <= w_char;
      o_attr <= attr;
      o_run  <= w_run;
      o_last <= cmd.last;
    end
  end

  assign m_axis_tvalid = ovalid;
  assign m_axis_tlast  = o_last;
  assign m_axis_tdata  = {2'b00, o_run, o_attr, o_char, o_row, o_col, o_page};

endmodule

/* rtl/core/tbd_ctrl.sv */
// ----------------------------------------------------------------------------
// tbd_ctrl
// Sequencer: walks the drawing parts of one command in order, one cell write
// per cycle while the output register is free, and marks the final write.
// ----------------------------------------------------------------------------
module tbd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output tbd_pkg::tbd_cmd_t  cmd,
  input  tbd_pkg::tbd_stat_t stat
);
  import tbd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_RUN} state_t;

  state_t          state;
  phase_t          phase;
  logic [CntW-1:0] cnt;

  ph_sel_t first_sel, next_sel, go_sel;
  logic    vertical, at_end, more_in_phase, cap, last;

  always_comb begin
    first_sel     = first_from(stat.has, PH_SINGLE);
    next_sel      = first_from(stat.has, PhW'(phase + 4'd1));
    vertical      = (phase == PH_VLINE) || (phase == PH_RIGHT) || (phase == PH_LEFT);
    at_end        = (phase == PH_VLINE) ? stat.row_at_br : stat.row_at_brm1;
    more_in_phase = vertical && !at_end;
    cap           = (cnt == CntW'(MaxWrites - 1));
    last          = cap || (!more_in_phase && !next_sel.found);
    go_sel        = (state == S_EVAL) ? first_sel : next_sel;

    in_ready = (state == S_IDLE);

    cmd             = '0;
    cmd.load        = (state == S_IDLE) && in_valid;
    cmd.phase       = phase;
    cmd.emit        = (state == S_RUN) && stat.out_free;
    cmd.last        = last;
    cmd.row_inc     = cmd.emit && !last && more_in_phase;
    // prime the row counter for the part about to start
    if (((state == S_EVAL) && first_sel.found) ||
        (cmd.emit && !last && !more_in_phase)) begin
      cmd.row_init_br = (go_sel.idx == PH_VLINE);
      cmd.row_init_in = (go_sel.idx == PH_RIGHT) || (go_sel.idx == PH_LEFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_SINGLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          cnt <= '0;
          if (first_sel.found) begin
            phase <= first_sel.idx;
            state <= S_RUN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RUN: begin
          if (cmd.emit) begin
            cnt <= CntW'(cnt + 1'b1);
            if (last) begin
              state <= S_IDLE;
            end else if (!more_in_phase) begin
              phase <= next_sel.idx;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("write issued while output register is held");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == S_IDLE))
    else $error("sequencer still busy after final write");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (cnt < CntW'(MaxWrites)))
    else $error("write count beyond limit");

  a_row_inc_vertical: assert property (@(posedge clk) disable iff (rst)
    cmd.row_inc |-> vertical)
    else $error("row advanced outside a vertical part");
`endif

endmodule

/* rtl/core/text_box_draw_sequencer.sv */
// ----------------------------------------------------------------------------
// text_box_draw_sequencer
// Turns one box command into the ordered character-cell writes that draw it.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one box command per transaction. m_axis carries the cell
//   writes; tlast marks the final write of a command. A command that draws
//   nothing (off screen, inverted, unknown style under CP437 glyphs, or a
//   mask that leaves no part to draw) gives no transaction at all.
//   cfg writes set glyph_set (index 0) and lower_right_enable (index 1);
//   write them only while no command is in flight.
// Timing:
//   A command is taken in S_IDLE and decoded in S_EVAL in the cycle after;
//   the sequencer then issues one write per cycle while the output register
//   is free. The first write reaches m_axis through S_RUN and the output
//   register. The next command is taken once the final write sits in the
//   output register; that write may still be waiting for m_axis_tready.
// Reset:
//   rst clears the sequencer, the output valid and the configuration
//   (ASCII glyphs, lower right corner enabled).
// Stall:
//   While m_axis_tready is low a held write stays in the output register and
//   the sequencer waits; no write is lost or repeated.
// ----------------------------------------------------------------------------
module text_box_draw_sequencer #(
  parameter int SCREEN_COLS = tbd_pkg::DefScreenCols,
  parameter int SCREEN_ROWS = tbd_pkg::DefScreenRows
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // page, left_col, top_row, right_col, bottom_row, attribute, box_style,
  // edge_mask (low bit first), zero padded
  input  logic [tbd_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // write_page, write_col, write_row, char_code, write_attribute,
  // run_length (low bit first), zero padded
  output logic [tbd_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic                         cfg_data
);
  import tbd_pkg::*;

  tbd_cmd_t  cmd;
  tbd_stat_t stat;

  assign cfg_ready = 1'b1;

  tbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  tbd_datapath #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .in_data       (s_axis_tdata),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text box draw sequencer. Box commands go in on
// s_axis; an in-bench planner works out the cell writes each one should give,
// and every m_axis transaction is checked field by field against the oldest
// planned write. Directed shapes cover both glyph sets and the corner gate,
// then random boxes run under each register setting with random gaps on both
// sides, a long output hold-off, and a final stretch with no gaps at all.
// ----------------------------------------------------------------------------
module tb;
  import tbd_pkg::*;

  localparam int Cols       = DefScreenCols;
  localparam int Rows       = DefScreenRows;
  localparam int SettleCyc  = 60;        // longer than a full command
  localparam int HoldCyc    = 400;       // long output hold-off
  localparam int CycleLimit = 1000000;

  // edge mask bits
  localparam logic [MaskW-1:0] E_TOP    = 8'h01;
  localparam logic [MaskW-1:0] E_UR     = 8'h02;
  localparam logic [MaskW-1:0] E_RIGHT  = 8'h04;
  localparam logic [MaskW-1:0] E_LR     = 8'h08;
  localparam logic [MaskW-1:0] E_BOTTOM = 8'h10;
  localparam logic [MaskW-1:0] E_LL     = 8'h20;
  localparam logic [MaskW-1:0] E_LEFT   = 8'h40;
  localparam logic [MaskW-1:0] E_UL     = 8'h80;
  localparam logic [MaskW-1:0] E_ALL    = 8'hFF;

  localparam logic [StyleW-1:0] STYLE_NONE  = 2'd0;
  localparam logic [StyleW-1:0] STYLE_SPARE = 2'd3;

  typedef struct {
    logic [PageW-1:0]  page;
    logic [ColW-1:0]   left_col;
    logic [RowW-1:0]   top_row;
    logic [ColW-1:0]   right_col;
    logic [RowW-1:0]   bottom_row;
    logic [AttrW-1:0]  attribute;
    logic [StyleW-1:0] box_style;
    logic [MaskW-1:0]  edge_mask;
  } box_cmd_t;

  typedef struct {
    logic [PageW-1:0] page;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic [CharW-1:0] ch;
    logic [AttrW-1:0] attr;
    logic [RunW-1:0]  run;
    logic             last;
  } cell_write_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = REG_GLYPH_SET;
  logic                cfg_data = 1'b0;

  // register copies, reset values
  logic glyph_cp437  = 1'b0;
  logic lr_corner_on = 1'b1;

  cell_write_t write_q[$];
  int          plan_cnt;
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  text_box_draw_sequencer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[text_box_draw_sequencer] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // planner
  // --------------------------------------------------------------------------
  function automatic void add_write(box_cmd_t c, int col, int row, logic [CharW-1:0] ch,
                                    int run);
    cell_write_t w;
    if (plan_cnt >= MaxWrites) return;
    w.page = c.page;
    w.col  = ColW'(col);
    w.row  = RowW'(row);
    w.ch   = ch;
    w.attr = c.attribute;
    w.run  = RunW'(run);
    w.last = 1'b0;
    write_q.push_back(w);
    plan_cnt++;
  endfunction

  function automatic int plan_writes(box_cmd_t c);
    int lc, rc, tr, br;
    logic [CharW-1:0] hz, vt, ul, ur, lr, ll;
    cell_write_t w;
    lc = c.left_col;
    rc = c.right_col;
    tr = c.top_row;
    br = c.bottom_row;
    plan_cnt = 0;
    if (lc >= Cols || rc >= Cols || tr >= Rows || br >= Rows) return 0;
    if (lc > rc || tr > br) return 0;
    if (lc == rc && tr == br) begin
      if (glyph_cp437) add_write(c, lc, tr, (c.box_style != STYLE_NONE) ? CH_DOT : CH_CIRCLE, 1);
      else add_write(c, lc, tr, CH_STAR, 1);
    end else begin
      if (glyph_cp437) begin
        if (c.box_style == STYLE_SINGLE) begin
          hz = CH_S_HZ; vt = CH_S_VT; ul = CH_S_UL; ur = CH_S_UR; lr = CH_S_LR; ll = CH_S_LL;
        end else if (c.box_style == STYLE_DOUBLE) begin
          hz = CH_D_HZ; vt = CH_D_VT; ul = CH_D_UL; ur = CH_D_UR; lr = CH_D_LR; ll = CH_D_LL;
        end else begin
          return 0;
        end
      end else begin
        hz = CH_DASH; vt = CH_BAR;
        ul = CH_PLUS; ur = CH_PLUS; lr = CH_PLUS; ll = CH_PLUS;
      end
      if (lc == rc && (c.edge_mask & (E_RIGHT | E_LEFT)) != 0) begin
        for (int r = tr; r <= br; r++) add_write(c, lc, r, vt, 1);
      end else if (tr == br && (c.edge_mask & (E_TOP | E_BOTTOM)) != 0) begin
        add_write(c, lc, tr, hz, rc - lc + 1);
      end else begin
        if (lc + 1 < rc && (c.edge_mask & E_TOP) != 0) add_write(c, lc + 1, tr, hz, rc - lc - 1);
        if ((c.edge_mask & E_UR) != 0) add_write(c, rc, tr, ur, 1);
        if ((c.edge_mask & E_RIGHT) != 0)
          for (int r = tr + 1; r < br; r++) add_write(c, rc, r, vt, 1);
        if (lr_corner_on && (c.edge_mask & E_LR) != 0) add_write(c, rc, br, lr, 1);
        if (lc + 1 < rc && (c.edge_mask & E_BOTTOM) != 0)
          add_write(c, lc + 1, br, hz, rc - lc - 1);
        if ((c.edge_mask & E_LL) != 0) add_write(c, lc, br, ll, 1);
        if ((c.edge_mask & E_LEFT) != 0)
          for (int r = tr + 1; r < br; r++) add_write(c, lc, r, vt, 1);
        if ((c.edge_mask & E_UL) != 0) add_write(c, lc, tr, ul, 1);
      end
    end
    if (plan_cnt > 0) begin
      w = write_q.pop_back();
      w.last = 1'b1;
      write_q.push_back(w);
    end
    return plan_cnt;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic box_cmd_t box_at(int page, int lc, int tr, int rc, int br,
                                      logic [StyleW-1:0] style, logic [MaskW-1:0] mask);
    box_cmd_t c;
    c.page       = PageW'(page);
    c.left_col   = ColW'(lc);
    c.top_row    = RowW'(tr);
    c.right_col  = ColW'(rc);
    c.bottom_row = RowW'(br);
    c.attribute  = AttrW'($urandom_range(0, 255));
    c.box_style  = style;
    c.edge_mask  = mask;
    return c;
  endfunction

  function automatic box_cmd_t random_box();
    box_cmd_t c;
    int lc, rc, tr, br, span;
    logic [MaskW-1:0] mask;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: mask = E_ALL;
      4:          mask = MaskW'(1 << $urandom_range(0, 7));
      default:    mask = MaskW'($urandom_range(0, 255));
    endcase
    lc = $urandom_range(0, Cols - 1);
    span = ($urandom_range(0, 7) == 0) ? Cols - 1 : 6;
    rc = lc + $urandom_range(0, (Cols - 1 - lc < span) ? Cols - 1 - lc : span);
    tr = $urandom_range(0, Rows - 1);
    span = ($urandom_range(0, 7) == 0) ? Rows - 1 : 5;
    br = tr + $urandom_range(0, (Rows - 1 - tr < span) ? Rows - 1 - tr : span);
    case ($urandom_range(0, 11))
      0: begin
        // push one coordinate off screen
        case ($urandom_range(0, 3))
          0: lc = $urandom_range(Cols, 127);
          1: rc = $urandom_range(Cols, 127);
          2: tr = $urandom_range(Rows, 31);
          default: br = $urandom_range(Rows, 31);
        endcase
      end
      1: begin
        if (lc != rc) begin
          span = lc; lc = rc; rc = span;
        end else begin
          span = tr; tr = br; br = span;
        end
      end
      default: ;
    endcase
    c = box_at($urandom_range(0, 7), lc, tr, rc, br, StyleW'($urandom_range(0, 3)), mask);
    if (glyph_cp437 && $urandom_range(0, 7) != 0) c.box_style = StyleW'($urandom_range(1, 2));
    return c;
  endfunction

  task automatic send_box(input box_cmd_t c);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({c.edge_mask, c.box_style, c.attribute, c.bottom_row,
                               c.right_col, c.top_row, c.left_col, c.page});
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    void'(plan_writes(c));
  endtask

  task automatic sender_gap();
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 15)) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (write_q.size() != 0) @(posedge clk);
  endtask

  // commands that draw nothing may still be in flight once the queue is empty
  task automatic go_idle();
    wait_drained();
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic configure(input logic gs, input logic lre);
    cfg_valid <= 1'b1;
    cfg_index <= REG_GLYPH_SET;
    cfg_data  <= gs;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    glyph_cp437 = gs;
    cfg_index <= REG_LOWER_RIGHT;
    cfg_data  <= lre;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    lr_corner_on = lre;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_boxes(input int count);
    repeat (count) begin
      if (!calm && $urandom_range(0, 3) == 0) sender_gap();
      send_box(random_box());
    end
  endtask

  // --------------------------------------------------------------------------
  // output side: random stalls and the long hold-off
  // --------------------------------------------------------------------------
  initial begin : drive_ready
    int held;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        for (held = 0; held < HoldCyc; held++) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] expv, input logic [7:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_writes
    cell_write_t w;
    if (!rst && m_axis_tvalid !== 1'b0 && m_axis_tready) begin
      if (write_q.size() == 0) begin
        $error("cell write with none pending: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        w = write_q.pop_front();
        check_field("write_page", 8'(w.page), 8'(m_axis_tdata[2:0]));
        check_field("write_col", 8'(w.col), 8'(m_axis_tdata[9:3]));
        check_field("write_row", 8'(w.row), 8'(m_axis_tdata[14:10]));
        check_field("char_code", w.ch, m_axis_tdata[22:15]);
        check_field("write_attribute", w.attr, m_axis_tdata[30:23]);
        check_field("run_length", 8'(w.run), 8'(m_axis_tdata[37:31]));
        check_field("last_write", 8'(w.last), 8'(m_axis_tlast));
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // runs on the reset settings: ASCII glyphs, lower right corner on
  task automatic test_ascii_shapes();
    send_box(box_at(0, 0, 0, Cols - 1, Rows - 1, STYLE_NONE, E_ALL));
    send_box(box_at(7, Cols - 1, Rows - 1, Cols - 1, Rows - 1, STYLE_SPARE, E_ALL));
    send_box(box_at(1, 10, 2, 9, 6, STYLE_SINGLE, E_ALL));
    send_box(box_at(2, 3, 9, 12, 8, STYLE_SINGLE, E_ALL));
    send_box(box_at(3, 127, 0, 10, 5, STYLE_SINGLE, E_ALL));
    send_box(box_at(4, 0, 0, 10, 31, STYLE_DOUBLE, E_ALL));
    send_box(box_at(5, 5, 0, 5, Rows - 1, STYLE_NONE, E_LEFT));
    send_box(box_at(6, 0, Rows - 1, Cols - 1, Rows - 1, STYLE_NONE, E_TOP));
    send_box(box_at(1, 20, 3, 20, 7, STYLE_NONE, E_UR | E_LR | E_LL | E_UL | E_TOP));
    send_box(box_at(2, 3, 1, 4, 4, STYLE_NONE, E_ALL));
    send_box(box_at(3, 30, 10, 40, 15, STYLE_NONE, 8'h00));
    send_box(box_at(4, 30, 10, 40, 15, STYLE_NONE, E_UL));
    send_box(box_at(5, 40, 12, 50, 12, STYLE_NONE, E_UR | E_LL));
  endtask

  task automatic test_cp437_shapes();
    go_idle();
    configure(1'b1, 1'b1);
    send_box(box_at(0, 0, 0, Cols - 1, Rows - 1, STYLE_SINGLE, E_ALL));
    send_box(box_at(7, 10, 5, 30, 9, STYLE_DOUBLE, E_ALL));
    send_box(box_at(1, 10, 5, 30, 9, STYLE_NONE, E_ALL));
    send_box(box_at(2, 40, 20, 40, 20, STYLE_SPARE, E_ALL));
    send_box(box_at(3, 0, 0, 0, 0, STYLE_NONE, 8'h00));
    send_box(box_at(4, 79, 2, 79, 20, STYLE_DOUBLE, E_RIGHT));
    send_box(box_at(5, 6, 24, 70, 24, STYLE_SINGLE, E_BOTTOM));
  endtask

  task automatic test_lower_right_gate();
    go_idle();
    configure(1'b1, 1'b0);
    send_box(box_at(6, 10, 5, 20, 10, STYLE_SINGLE, E_LR));
    send_box(box_at(7, 10, 5, 20, 10, STYLE_DOUBLE, E_ALL));
    go_idle();
    configure(1'b0, 1'b0);
    send_box(box_at(0, 1, 1, 8, 4, STYLE_NONE, E_ALL));
    send_box(box_at(1, 1, 1, 8, 4, STYLE_NONE, E_LR));
    go_idle();
    configure(1'b0, 1'b1);
  endtask

  // hold the output while commands keep coming, wait until all is out, then send more
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (6) send_box(box_at($urandom_range(0, 7), 0, 0, Cols - 1, Rows - 1,
                               STYLE_DOUBLE, E_ALL));
    wait_drained();
    repeat (4) send_box(random_box());
  endtask

  task automatic test_random_settings();
    go_idle();
    configure(1'b1, 1'b1);
    random_boxes(35);
    go_idle();
    configure(1'b1, 1'b0);
    random_boxes(35);
    go_idle();
    configure(1'b0, 1'b0);
    random_boxes(35);
    go_idle();
    configure(1'b0, 1'b1);
    random_boxes(35);
  endtask

  task automatic test_quiet_tail();
    go_idle();
    calm = 1'b1;
    configure(1'(($urandom_range(0, 1))), 1'b1);
    random_boxes(36);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_ascii_shapes();
    test_cp437_shapes();
    test_lower_right_gate();
    test_backpressure();
    test_random_settings();
    test_quiet_tail();
    go_idle();
    if (errors == 0) begin
      $display("[text_box_draw_sequencer] OK");
    end else begin
      $display("[text_box_draw_sequencer] ERROR");
    end
    $finish;
  end

endmodule

/* text_box_draw_sequencer.f */
rtl/core/tbd_pkg.sv
rtl/core/tbd_datapath.sv
rtl/core/tbd_ctrl.sv
rtl/core/text_box_draw_sequencer.sv
dv/tb.sv
